// ===== design/mfam_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the mixed fraction add and multiply block
package mfam_pkg;

  localparam int PartWidth  = 8;
  localparam int DataWidth  = 32;
  localparam int CountWidth = $clog2(DataWidth);

  typedef struct packed {
    logic [PartWidth-1:0] first_whole;
    logic [PartWidth-1:0] first_part_num;
    logic [PartWidth-1:0] first_part_den;
    logic [PartWidth-1:0] second_whole;
    logic [PartWidth-1:0] second_part_num;
    logic [PartWidth-1:0] second_part_den;
  } in_item_t;

  typedef struct packed {
    logic [15:0] first_num;
    logic [7:0]  first_den;
    logic [15:0] second_num;
    logic [7:0]  second_den;
    logic [24:0] sum_num;
    logic [15:0] sum_den;
    logic [31:0] prod_num;
    logic [15:0] prod_den;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StGcd,
    StDiv,
    StStore,
    StMul1,
    StMul2
  } state_e;

  typedef enum logic [1:0] {
    SelFirst,
    SelSecond,
    SelSum,
    SelProd
  } sel_e;

  typedef struct packed {
    logic capture;
    logic load;
    logic gcd_step;
    logic div_start;
    logic div_step;
    logic store;
    logic mul1;
    logic mul2;
    sel_e sel;
  } cmd_t;

  typedef struct packed {
    logic zero;
    logic gcd_done;
    logic div_done;
  } status_t;

endpackage

// ===== design/mfam_ctrl.sv =====
`timescale 1ns / 1ps
// controller state machine sequencing the four reductions
module mfam_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  mfam_pkg::status_t status_i,
  output mfam_pkg::cmd_t    cmd_o
);
  import mfam_pkg::*;

  state_e state_q, state_d;
  sel_e   sel_q, sel_d;
  logic   out_valid_q, out_valid_d;
  logic   store_ok;

  assign store_ok = (sel_q != SelProd) || !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      sel_q       <= SelFirst;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StLoad;
          sel_d   = SelFirst;
        end
      end
      StLoad: state_d = status_i.zero ? StDiv : StGcd;
      StGcd: begin
        if (status_i.gcd_done) state_d = StDiv;
      end
      StDiv: begin
        if (status_i.div_done) state_d = StStore;
      end
      StStore: begin
        if (store_ok) begin
          unique case (sel_q)
            SelFirst: begin
              state_d = StLoad;
              sel_d   = SelSecond;
            end
            SelSecond: state_d = StMul1;
            SelSum: begin
              state_d = StLoad;
              sel_d   = SelProd;
            end
            SelProd: state_d = StIdle;
            default: state_d = StIdle;
          endcase
        end
      end
      StMul1: state_d = StMul2;
      StMul2: begin
        state_d = StLoad;
        sel_d   = SelSum;
      end
      default: state_d = StIdle;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    cmd_o.sel   = sel_q;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      StLoad: cmd_o.load = 1'b1;
      StGcd: begin
        if (status_i.gcd_done) cmd_o.div_start = 1'b1;
        else cmd_o.gcd_step = 1'b1;
      end
      StDiv: cmd_o.div_step = 1'b1;
      StStore: begin
        cmd_o.store = store_ok;
        if (store_ok && sel_q == SelProd) out_valid_d = 1'b1;
      end
      StMul1: cmd_o.mul1 = 1'b1;
      StMul2: cmd_o.mul2 = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/mfam_dp.sv =====
`timescale 1ns / 1ps
// datapath: operand forming, binary gcd, restoring division, cross multiplication and result registers
module mfam_dp (
  input  logic                clk_i,
  input  mfam_pkg::in_item_t  in_item_i,
  input  mfam_pkg::cmd_t      cmd_i,
  output mfam_pkg::status_t   status_o,
  output mfam_pkg::out_item_t out_item_o
);
  import mfam_pkg::*;

  in_item_t              in_q;
  logic [DataWidth-1:0]  a_q, b_q, g_q, n_q, d_q;
  logic [DataWidth:0]    rn_q, rd_q;
  logic [CountWidth-1:0] k_q, cnt_q;
  logic [15:0]           fa_n_q, fb_n_q;
  logic [7:0]            fa_d_q, fb_d_q;
  logic [23:0]           m1_q, m2_q;
  logic [24:0]           sum_q, s_n_q;
  logic [31:0]           pn_q;
  logic [15:0]           pd_q, s_d_q;
  out_item_t             out_q;

  logic [DataWidth-1:0] ld_n, ld_d;
  logic [DataWidth:0]   rn_sh, rd_sh;
  logic                 n_ge, d_ge;

  always_comb begin
    unique case (cmd_i.sel)
      SelFirst: begin
        ld_n = DataWidth'(in_q.first_whole * in_q.first_part_den + 16'(in_q.first_part_num));
        ld_d = DataWidth'(in_q.first_part_den);
      end
      SelSecond: begin
        ld_n = DataWidth'(in_q.second_whole * in_q.second_part_den
                          + 16'(in_q.second_part_num));
        ld_d = DataWidth'(in_q.second_part_den);
      end
      SelSum: begin
        ld_n = DataWidth'(sum_q);
        ld_d = DataWidth'(pd_q);
      end
      default: begin
        ld_n = pn_q;
        ld_d = DataWidth'(pd_q);
      end
    endcase
  end

  assign status_o.zero     = (ld_n == '0) || (ld_d == '0);
  assign status_o.gcd_done = (a_q == '0) || (b_q == '0);
  assign status_o.div_done = (cnt_q == CountWidth'(DataWidth - 1));

  assign rn_sh = {rn_q[DataWidth-1:0], n_q[DataWidth-1]};
  assign rd_sh = {rd_q[DataWidth-1:0], d_q[DataWidth-1]};
  assign n_ge  = rn_sh >= {1'b0, g_q};
  assign d_ge  = rd_sh >= {1'b0, g_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) in_q <= in_item_i;

    if (cmd_i.load) begin
      a_q   <= ld_n;
      b_q   <= ld_d;
      n_q   <= ld_n;
      d_q   <= ld_d;
      k_q   <= '0;
      g_q   <= DataWidth'(1);
      cnt_q <= '0;
      rn_q  <= '0;
      rd_q  <= '0;
    end else if (cmd_i.gcd_step) begin
      if (!a_q[0] && !b_q[0]) begin
        a_q <= a_q >> 1;
        b_q <= b_q >> 1;
        k_q <= k_q + 1'b1;
      end else if (!a_q[0]) begin
        a_q <= a_q >> 1;
      end else if (!b_q[0]) begin
        b_q <= b_q >> 1;
      end else if (a_q >= b_q) begin
        a_q <= a_q - b_q;
      end else begin
        b_q <= b_q - a_q;
      end
    end else if (cmd_i.div_start) begin
      g_q   <= (a_q | b_q) << k_q;
      cnt_q <= '0;
      rn_q  <= '0;
      rd_q  <= '0;
    end else if (cmd_i.div_step) begin
      rn_q  <= n_ge ? rn_sh - {1'b0, g_q} : rn_sh;
      rd_q  <= d_ge ? rd_sh - {1'b0, g_q} : rd_sh;
      n_q   <= {n_q[DataWidth-2:0], n_ge};
      d_q   <= {d_q[DataWidth-2:0], d_ge};
      cnt_q <= cnt_q + 1'b1;
    end

    if (cmd_i.mul1) begin
      m1_q <= fa_n_q * fb_d_q;
      m2_q <= fb_n_q * fa_d_q;
    end
    if (cmd_i.mul2) begin
      sum_q <= 25'(m1_q) + 25'(m2_q);
      pn_q  <= fa_n_q * fb_n_q;
      pd_q  <= fa_d_q * fb_d_q;
    end

    if (cmd_i.store) begin
      unique case (cmd_i.sel)
        SelFirst: begin
          fa_n_q <= n_q[15:0];
          fa_d_q <= d_q[7:0];
        end
        SelSecond: begin
          fb_n_q <= n_q[15:0];
          fb_d_q <= d_q[7:0];
        end
        SelSum: begin
          s_n_q <= n_q[24:0];
          s_d_q <= d_q[15:0];
        end
        default: begin
          out_q.first_num  <= fa_n_q;
          out_q.first_den  <= fa_d_q;
          out_q.second_num <= fb_n_q;
          out_q.second_den <= fb_d_q;
          out_q.sum_num    <= s_n_q;
          out_q.sum_den    <= s_d_q;
          out_q.prod_num   <= n_q;
          out_q.prod_den   <= d_q[15:0];
        end
      endcase
    end
  end

  assign out_item_o = out_q;

endmodule

// ===== design/mixed_fraction_add_multiply_top.sv =====
`timescale 1ns / 1ps
// Mixed fraction add and multiply: each transaction turns two mixed numbers into
// reduced improper fractions, then forms their reduced sum and product. One
// transaction is worked at a time through a shared reduction unit that is used
// four times: a binary gcd taking one step per cycle, followed by a restoring
// division of numerator and denominator. A finished result waits in an output
// register, and the next transaction is accepted while it waits.
module mixed_fraction_add_multiply_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mfam_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mfam_pkg::out_item_t out_item_o
);
  import mfam_pkg::*;

  cmd_t    cmd;
  status_t status;

  mfam_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mfam_dp u_dp (
    .clk_i      (clk_i),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_item_o (out_item_o)
  );

endmodule

// ===== design/mfam_checker.sv =====
`timescale 1ns / 1ps
// port-level checker for the mixed fraction block and its bind
module mfam_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input mfam_pkg::out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transaction");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction taken while busy");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared straight after input");

endmodule

bind mixed_fraction_add_multiply_top mfam_checker u_mfam_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
